@@ sv/thc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and tables for the tilt-compensated heading block.
// No dependencies; used by every other file of the block.

package thc_pkg;

	localparam int AVG_COUNT    = 5;
	localparam int CORDIC_STEPS = 16;
	localparam int DIV_BITS     = 28;
	localparam int SQRT_ITERS   = 20;
	localparam int MUL_CHUNKS   = 3;

	localparam logic [3:0] STEP_EZ  = 4'd5;
	localparam logic [3:0] STEP_SSQ = 4'd8;
	localparam logic [3:0] STEP_YV  = 4'd11;

	localparam logic signed [24:0] ANG_90   = 25'sd5898240;
	localparam logic signed [24:0] ANG_180  = 25'sd11796480;
	localparam logic [24:0]        HALF_DEG = 25'd32768;
	localparam logic [17:0]        RIB_MUL  = 18'd205;
	localparam int                 RIB_SHIFT = 11;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [11:0] mag_x;
		logic signed [11:0] mag_y;
		logic signed [11:0] mag_z;
	} in_item_t;

	typedef struct packed {
		logic [8:0] heading_deg;
		logic [5:0] ribbon_offset;
		logic       degenerate;
	} out_item_t;

	typedef enum logic [2:0] {
		CFG_MIN_X = 3'd0,
		CFG_MIN_Y = 3'd1,
		CFG_MIN_Z = 3'd2,
		CFG_MAX_X = 3'd3,
		CFG_MAX_Y = 3'd4,
		CFG_MAX_Z = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		A_MX, A_MY, A_MZ, A_AX, A_AY, A_AZ, A_EX, A_EY, A_EZ
	} a_sel_t;

	typedef enum logic [1:0] {
		B_AX, B_AY, B_AZ, B_NORM
	} b_sel_t;

	typedef enum logic [1:0] {
		CMB_LOAD, CMB_ADD, CMB_SUB, CMB_NEG
	} comb_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_EX, DST_EY, DST_EZ, DST_SSQ, DST_NY, DST_YV
	} dst_t;

	typedef struct packed {
		a_sel_t a;
		b_sel_t b;
		comb_t  c;
		dst_t   d;
	} step_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_INIT, ST_DIV_RUN, ST_DIV_ADD, ST_CHECK, ST_MUL, ST_COMB,
		ST_ECHECK, ST_SQRT_INIT, ST_SQRT_RUN, ST_NORM_LOAD, ST_NORM_SHIFT,
		ST_CORDIC_INIT, ST_CORDIC_RUN, ST_ANGLE, ST_WRITE
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       div_init;
		logic       div_step;
		logic       mag_add;
		logic [1:0] axis;
		logic       count_inc;
		logic       mul_step;
		logic       mul_first;
		logic [1:0] mul_chunk;
		logic       comb;
		logic [3:0] step;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       norm_load;
		logic       norm_shift;
		logic       cordic_init;
		logic       cordic_step;
		logic [4:0] iter;
		logic       angle;
		logic       out_load;
		logic       degen;
		logic       batch_clear;
	} cmd_t;

	typedef struct packed {
		logic batch_last;
		logic fault;
		logic e_zero;
		logic fits;
	} status_t;

	// Product schedule: cross products, squared length, then north and scaled east.
	function automatic step_t step_spec(input logic [3:0] idx);
		step_t s;
		begin
			case (idx)
				4'd0: s = '{A_MY, B_AZ, CMB_LOAD, DST_NONE};
				4'd1: s = '{A_MZ, B_AY, CMB_SUB, DST_EX};
				4'd2: s = '{A_MZ, B_AX, CMB_LOAD, DST_NONE};
				4'd3: s = '{A_MX, B_AZ, CMB_SUB, DST_EY};
				4'd4: s = '{A_MX, B_AY, CMB_LOAD, DST_NONE};
				4'd5: s = '{A_MY, B_AX, CMB_SUB, DST_EZ};
				4'd6: s = '{A_AX, B_AX, CMB_LOAD, DST_NONE};
				4'd7: s = '{A_AY, B_AY, CMB_ADD, DST_NONE};
				4'd8: s = '{A_AZ, B_AZ, CMB_ADD, DST_SSQ};
				4'd9: s = '{A_EX, B_AZ, CMB_LOAD, DST_NONE};
				4'd10: s = '{A_EZ, B_AX, CMB_SUB, DST_NY};
				4'd11: s = '{A_EY, B_NORM, CMB_NEG, DST_YV};
				default: s = '{A_MX, B_AX, CMB_LOAD, DST_NONE};
			endcase
			return s;
		end
	endfunction

	// atan(2^-i) in Q16 degrees
	function automatic logic [21:0] atan_q16(input logic [4:0] i);
		logic [21:0] v;
		begin
			case (i)
				5'd0: v = 22'd2949120;
				5'd1: v = 22'd1740967;
				5'd2: v = 22'd919879;
				5'd3: v = 22'd466945;
				5'd4: v = 22'd234379;
				5'd5: v = 22'd117304;
				5'd6: v = 22'd58666;
				5'd7: v = 22'd29335;
				5'd8: v = 22'd14668;
				5'd9: v = 22'd7334;
				5'd10: v = 22'd3667;
				5'd11: v = 22'd1833;
				5'd12: v = 22'd917;
				5'd13: v = 22'd458;
				5'd14: v = 22'd229;
				5'd15: v = 22'd115;
				5'd16: v = 22'd57;
				5'd17: v = 22'd29;
				5'd18: v = 22'd14;
				5'd19: v = 22'd7;
				5'd20: v = 22'd4;
				5'd21: v = 22'd2;
				5'd22: v = 22'd1;
				default: v = 22'd0;
			endcase
			return v;
		end
	endfunction

endpackage

@@ sv/thc_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine for the heading block: issues datapath commands.
// Depends on thc_pkg.

module thc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  thc_pkg::status_t  status,
	output thc_pkg::cmd_t     cmd
);

	thc_pkg::state_t state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic [4:0] iter_q, iter_d;
	logic [3:0] step_q, step_d;
	logic [1:0] chunk_q, chunk_d;
	logic       degen_q, degen_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= thc_pkg::ST_IDLE;
			axis_q      <= '0;
			iter_q      <= '0;
			step_q      <= '0;
			chunk_q     <= '0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			iter_q  <= iter_d;
			step_q  <= step_d;
			chunk_q <= chunk_d;
			degen_q <= degen_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		axis_d        = axis_q;
		iter_d        = iter_q;
		step_d        = step_q;
		chunk_d       = chunk_q;
		degen_d       = degen_q;
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.iter      = iter_q;
		cmd.step      = step_q;
		cmd.mul_chunk = chunk_q;
		cmd.degen     = degen_q;
		in_stall      = 1'b1;
		case (state_q)
			thc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					axis_d      = '0;
					state_d     = thc_pkg::ST_DIV_INIT;
				end
			end
			thc_pkg::ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				iter_d       = '0;
				state_d      = thc_pkg::ST_DIV_RUN;
			end
			thc_pkg::ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q + 5'd1;
				if (iter_q == 5'(thc_pkg::DIV_BITS - 1)) begin
					state_d = thc_pkg::ST_DIV_ADD;
				end
			end
			thc_pkg::ST_DIV_ADD: begin
				cmd.mag_add = 1'b1;
				if (axis_q == 2'd2) begin
					state_d = thc_pkg::ST_CHECK;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = thc_pkg::ST_DIV_INIT;
				end
			end
			thc_pkg::ST_CHECK: begin
				if (!status.batch_last) begin
					cmd.count_inc = 1'b1;
					state_d       = thc_pkg::ST_IDLE;
				end else if (status.fault) begin
					degen_d = 1'b1;
					state_d = thc_pkg::ST_WRITE;
				end else begin
					step_d  = '0;
					chunk_d = '0;
					state_d = thc_pkg::ST_MUL;
				end
			end
			thc_pkg::ST_MUL: begin
				cmd.mul_step  = 1'b1;
				cmd.mul_first = (chunk_q == 2'd0);
				if (chunk_q == 2'(thc_pkg::MUL_CHUNKS - 1)) begin
					chunk_d = '0;
					state_d = thc_pkg::ST_COMB;
				end else begin
					chunk_d = chunk_q + 2'd1;
				end
			end
			thc_pkg::ST_COMB: begin
				cmd.comb = 1'b1;
				step_d   = step_q + 4'd1;
				case (step_q)
					thc_pkg::STEP_EZ:  state_d = thc_pkg::ST_ECHECK;
					thc_pkg::STEP_SSQ: state_d = thc_pkg::ST_SQRT_INIT;
					thc_pkg::STEP_YV:  state_d = thc_pkg::ST_NORM_LOAD;
					default:           state_d = thc_pkg::ST_MUL;
				endcase
			end
			thc_pkg::ST_ECHECK: begin
				if (status.e_zero) begin
					degen_d = 1'b1;
					state_d = thc_pkg::ST_WRITE;
				end else begin
					state_d = thc_pkg::ST_MUL;
				end
			end
			thc_pkg::ST_SQRT_INIT: begin
				cmd.sqrt_init = 1'b1;
				iter_d        = '0;
				state_d       = thc_pkg::ST_SQRT_RUN;
			end
			thc_pkg::ST_SQRT_RUN: begin
				cmd.sqrt_step = 1'b1;
				iter_d        = iter_q + 5'd1;
				if (iter_q == 5'(thc_pkg::SQRT_ITERS - 1)) begin
					state_d = thc_pkg::ST_MUL;
				end
			end
			thc_pkg::ST_NORM_LOAD: begin
				cmd.norm_load = 1'b1;
				state_d       = thc_pkg::ST_NORM_SHIFT;
			end
			thc_pkg::ST_NORM_SHIFT: begin
				if (status.fits) begin
					state_d = thc_pkg::ST_CORDIC_INIT;
				end else begin
					cmd.norm_shift = 1'b1;
				end
			end
			thc_pkg::ST_CORDIC_INIT: begin
				cmd.cordic_init = 1'b1;
				iter_d          = '0;
				state_d         = thc_pkg::ST_CORDIC_RUN;
			end
			thc_pkg::ST_CORDIC_RUN: begin
				cmd.cordic_step = 1'b1;
				iter_d          = iter_q + 5'd1;
				if (iter_q == 5'(thc_pkg::CORDIC_STEPS - 1)) begin
					state_d = thc_pkg::ST_ANGLE;
				end
			end
			thc_pkg::ST_ANGLE: begin
				cmd.angle = 1'b1;
				state_d   = thc_pkg::ST_WRITE;
			end
			thc_pkg::ST_WRITE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.out_load    = 1'b1;
					cmd.batch_clear = 1'b1;
					degen_d         = 1'b0;
					state_d         = thc_pkg::ST_IDLE;
				end
			end
			default: state_d = thc_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ sv/thc_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the heading block: calibration registers, sums, serial divider,
// chunked multiplier, square root, CORDIC and result register. Depends on thc_pkg.

module thc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic signed [11:0]  cfg_data,
	input  thc_pkg::in_item_t   in_data,
	input  thc_pkg::cmd_t       cmd,
	output thc_pkg::status_t    status,
	output thc_pkg::out_item_t  out_data
);

	logic signed [11:0] mag_min_q [3];
	logic signed [11:0] mag_max_q [3];
	logic signed [18:0] asum_q [3];
	logic signed [19:0] msum_q [3];
	logic signed [11:0] mag_in_q [3];
	logic [2:0]         cnt_q;
	logic               fault_q;

	// divider
	logic signed [11:0] m_sel, mn_sel, mx_sel;
	logic signed [12:0] span, diff;
	logic [11:0]        abs_span, abs_diff;
	logic [27:0]        dividend;
	logic [27:0]        div_d_q, div_quo_q;
	logic [11:0]        div_rem_q, div_as_q;
	logic               div_neg_q, div_zero_q;
	logic [12:0]        trial;
	logic signed [29:0] q_signed, q_off;
	logic signed [15:0] s_sat;
	logic signed [19:0] s_ext;

	// multiplier
	thc_pkg::step_t     spec;
	logic signed [40:0] a_val;
	logic signed [23:0] b_val;
	logic signed [8:0]  chunk_s;
	logic signed [49:0] partial;
	logic signed [63:0] mul_acc_q, res_q, comb_val;
	logic signed [40:0] ex_q, ey_q, ez_q;
	logic [39:0]        ssq_q;
	logic signed [63:0] ny_q, yv_q, ny_neg, yv_neg;

	// square root
	logic [39:0] sq_v_q, sq_r_q, sq_bit_q, sq_rb;

	// normalization and CORDIC
	logic [62:0]        ux_q, uy_q;
	logic               sx_q, sy_q;
	logic signed [33:0] x_q, y_q, xs, ys;
	logic signed [24:0] z_q, atan_v;

	// angle
	logic signed [24:0] z_clamp, ang, ang_s, ang_neg;
	logic [23:0]        ang_mag;
	logic [24:0]        rsum;
	logic [8:0]         r_deg, deg_next, deg_q, head_sel;
	logic [17:0]        rib_prod;
	thc_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_min_q[0] <= -12'sd642;
			mag_min_q[1] <= -12'sd496;
			mag_min_q[2] <= -12'sd462;
			mag_max_q[0] <= 12'sd340;
			mag_max_q[1] <= 12'sd517;
			mag_max_q[2] <= 12'sd416;
		end else if (cfg_we) begin
			case (thc_pkg::cfg_idx_t'(cfg_index))
				thc_pkg::CFG_MIN_X: mag_min_q[0] <= cfg_data;
				thc_pkg::CFG_MIN_Y: mag_min_q[1] <= cfg_data;
				thc_pkg::CFG_MIN_Z: mag_min_q[2] <= cfg_data;
				thc_pkg::CFG_MAX_X: mag_max_q[0] <= cfg_data;
				thc_pkg::CFG_MAX_Y: mag_max_q[1] <= cfg_data;
				thc_pkg::CFG_MAX_Z: mag_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// running sums, batch count and span fault
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				asum_q[k] <= '0;
				msum_q[k] <= '0;
			end
			cnt_q   <= '0;
			fault_q <= 1'b0;
		end else if (cmd.batch_clear) begin
			for (int k = 0; k < 3; k++) begin
				asum_q[k] <= '0;
				msum_q[k] <= '0;
			end
			cnt_q   <= '0;
			fault_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				asum_q[0] <= asum_q[0] + {{3{in_data.accel_x[15]}}, in_data.accel_x};
				asum_q[1] <= asum_q[1] + {{3{in_data.accel_y[15]}}, in_data.accel_y};
				asum_q[2] <= asum_q[2] + {{3{in_data.accel_z[15]}}, in_data.accel_z};
			end
			for (int k = 0; k < 3; k++) begin
				if (cmd.mag_add && cmd.axis == 2'(k)) begin
					msum_q[k] <= msum_q[k] + s_ext;
				end
			end
			if (cmd.count_inc) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (cmd.div_init && span == 13'sd0) begin
				fault_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mag_in_q[0] <= in_data.mag_x;
			mag_in_q[1] <= in_data.mag_y;
			mag_in_q[2] <= in_data.mag_z;
		end
	end

	// ---- per-axis calibration divide ----
	always_comb begin
		case (cmd.axis)
			2'd0: begin
				m_sel = mag_in_q[0]; mn_sel = mag_min_q[0]; mx_sel = mag_max_q[0];
			end
			2'd1: begin
				m_sel = mag_in_q[1]; mn_sel = mag_min_q[1]; mx_sel = mag_max_q[1];
			end
			default: begin
				m_sel = mag_in_q[2]; mn_sel = mag_min_q[2]; mx_sel = mag_max_q[2];
			end
		endcase
		span     = {mx_sel[11], mx_sel} - {mn_sel[11], mn_sel};
		diff     = {m_sel[11], m_sel} - {mn_sel[11], mn_sel};
		abs_span = span[12] ? 12'(-span) : span[11:0];
		abs_diff = diff[12] ? 12'(-diff) : diff[11:0];
		// rounded magnitude: (|diff| * 32768 + |span| / 2) / |span|
		dividend = {1'b0, abs_diff, 15'd0} + {17'd0, abs_span[11:1]};
		trial    = {div_rem_q, div_d_q[27]};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			div_d_q    <= dividend;
			div_rem_q  <= '0;
			div_quo_q  <= '0;
			div_as_q   <= abs_span;
			div_neg_q  <= diff[12] ^ span[12];
			div_zero_q <= (span == 13'sd0);
		end else if (cmd.div_step) begin
			div_d_q <= {div_d_q[26:0], 1'b0};
			if (trial >= {1'b0, div_as_q}) begin
				div_rem_q <= 12'(trial - {1'b0, div_as_q});
				div_quo_q <= {div_quo_q[26:0], 1'b1};
			end else begin
				div_rem_q <= trial[11:0];
				div_quo_q <= {div_quo_q[26:0], 1'b0};
			end
		end
	end

	always_comb begin
		q_signed = div_neg_q ? -$signed({2'b00, div_quo_q}) : $signed({2'b00, div_quo_q});
		q_off    = q_signed - 30'sd16384;
		if (q_off > 30'sd32767) begin
			s_sat = 16'sh7fff;
		end else if (q_off < -30'sd32768) begin
			s_sat = -16'sd32768;
		end else begin
			s_sat = q_off[15:0];
		end
		s_ext = div_zero_q ? 20'sd0 : {{4{s_sat[15]}}, s_sat};
	end

	// ---- chunked multiplier, top byte of B first ----
	assign spec = thc_pkg::step_spec(cmd.step);

	always_comb begin
		case (spec.a)
			thc_pkg::A_MX: a_val = {{21{msum_q[0][19]}}, msum_q[0]};
			thc_pkg::A_MY: a_val = {{21{msum_q[1][19]}}, msum_q[1]};
			thc_pkg::A_MZ: a_val = {{21{msum_q[2][19]}}, msum_q[2]};
			thc_pkg::A_AX: a_val = {{22{asum_q[0][18]}}, asum_q[0]};
			thc_pkg::A_AY: a_val = {{22{asum_q[1][18]}}, asum_q[1]};
			thc_pkg::A_AZ: a_val = {{22{asum_q[2][18]}}, asum_q[2]};
			thc_pkg::A_EX: a_val = ex_q;
			thc_pkg::A_EY: a_val = ey_q;
			thc_pkg::A_EZ: a_val = ez_q;
			default:       a_val = '0;
		endcase
		case (spec.b)
			thc_pkg::B_AX: b_val = {{5{asum_q[0][18]}}, asum_q[0]};
			thc_pkg::B_AY: b_val = {{5{asum_q[1][18]}}, asum_q[1]};
			thc_pkg::B_AZ: b_val = {{5{asum_q[2][18]}}, asum_q[2]};
			default:       b_val = {4'd0, sq_r_q[19:0]};
		endcase
		case (cmd.mul_chunk)
			2'd0:    chunk_s = {b_val[23], b_val[23:16]};
			2'd1:    chunk_s = {1'b0, b_val[15:8]};
			default: chunk_s = {1'b0, b_val[7:0]};
		endcase
		partial = a_val * chunk_s;
		case (spec.c)
			thc_pkg::CMB_LOAD: comb_val = mul_acc_q;
			thc_pkg::CMB_ADD:  comb_val = res_q + mul_acc_q;
			thc_pkg::CMB_SUB:  comb_val = res_q - mul_acc_q;
			default:           comb_val = 64'sd0 - mul_acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			if (cmd.mul_first) begin
				mul_acc_q <= {{14{partial[49]}}, partial};
			end else begin
				mul_acc_q <= (mul_acc_q <<< 8) + {{14{partial[49]}}, partial};
			end
		end
		if (cmd.comb) begin
			res_q <= comb_val;
			case (spec.d)
				thc_pkg::DST_EX:  ex_q  <= comb_val[40:0];
				thc_pkg::DST_EY:  ey_q  <= comb_val[40:0];
				thc_pkg::DST_EZ:  ez_q  <= comb_val[40:0];
				thc_pkg::DST_SSQ: ssq_q <= comb_val[39:0];
				thc_pkg::DST_NY:  ny_q  <= comb_val;
				thc_pkg::DST_YV:  yv_q  <= comb_val;
				default: ;
			endcase
		end
	end

	// ---- integer square root, one result bit per step ----
	assign sq_rb = sq_r_q + sq_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sq_v_q   <= ssq_q;
			sq_r_q   <= '0;
			sq_bit_q <= 40'd1 << 38;
		end else if (cmd.sqrt_step) begin
			if (sq_v_q >= sq_rb) begin
				sq_v_q <= sq_v_q - sq_rb;
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// ---- operand magnitudes, shifted down below 2^30 ----
	assign ny_neg = -ny_q;
	assign yv_neg = -yv_q;

	always_ff @(posedge clk) begin
		if (cmd.norm_load) begin
			ux_q <= ny_q[63] ? ny_neg[62:0] : ny_q[62:0];
			uy_q <= yv_q[63] ? yv_neg[62:0] : yv_q[62:0];
			sx_q <= !ny_q[63] && (ny_q != 64'sd0);
			sy_q <= yv_q[63];
		end else if (cmd.norm_shift) begin
			ux_q <= ux_q >> 1;
			uy_q <= uy_q >> 1;
		end
	end

	// ---- vectoring CORDIC ----
	assign xs     = x_q >>> cmd.iter;
	assign ys     = y_q >>> cmd.iter;
	assign atan_v = {3'b000, thc_pkg::atan_q16(cmd.iter)};

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			x_q <= {4'd0, ux_q[29:0]};
			y_q <= {4'd0, uy_q[29:0]};
			z_q <= '0;
		end else if (cmd.cordic_step) begin
			if (y_q > 34'sd0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end
		end
	end

	// ---- quadrant, rounding and wrap ----
	always_comb begin
		if (z_q < 25'sd0) begin
			z_clamp = '0;
		end else if (z_q > thc_pkg::ANG_90) begin
			z_clamp = thc_pkg::ANG_90;
		end else begin
			z_clamp = z_q;
		end
		ang     = sx_q ? thc_pkg::ANG_180 - z_clamp : z_clamp;
		ang_s   = sy_q ? -ang : ang;
		ang_neg = -ang_s;
		ang_mag = ang_s[24] ? ang_neg[23:0] : ang_s[23:0];
		rsum    = {1'b0, ang_mag} + thc_pkg::HALF_DEG;
		r_deg   = rsum[24:16];
		deg_next = (ang_s[24] && r_deg != 9'd0) ? 9'd360 - r_deg : r_deg;
		if (deg_next > 9'd359) begin
			deg_next = deg_next - 9'd360;
		end
		head_sel = cmd.degen ? 9'd0 : deg_q;
		// divide by ten as multiply by 205 and shift
		rib_prod = ({9'd0, head_sel} + 18'd5) * thc_pkg::RIB_MUL;
	end

	always_ff @(posedge clk) begin
		if (cmd.angle) begin
			deg_q <= deg_next;
		end
		if (cmd.out_load) begin
			out_q.heading_deg   <= head_sel;
			out_q.ribbon_offset <= rib_prod[thc_pkg::RIB_SHIFT +: 6];
			out_q.degenerate    <= cmd.degen;
		end
	end

	assign out_data = out_q;

	assign status.batch_last = (cnt_q == 3'(thc_pkg::AVG_COUNT - 1));
	assign status.fault      = fault_q;
	assign status.e_zero     = (ex_q == 41'sd0) && (ey_q == 41'sd0) && (ez_q == 41'sd0);
	assign status.fits       = ~|(ux_q[62:30] | uy_q[62:30]);

endmodule

@@ sv/tilt_compensated_heading.sv @@
`timescale 1ns / 1ps
// Top level of the tilt-compensated compass heading block.
// Depends on thc_pkg, thc_ctrl and thc_datapath.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one accelerometer and one
//    magnetometer sample per transfer. in_stall is low only while idle.
//  - Output channel (out_valid / out_stall / out_data): one heading result
//    for every fifth input transfer, none for the others.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
//    calibration min/max registers; cfg_ready is always high, unknown indexes
//    are dropped. Write only while the block is idle.
//  - Each input runs through the serial divider before the block is ready
//    again: one quotient bit per cycle, 28 bits for each of 3 axes.
//  - The item closing a batch then runs the cross products on the chunked
//    multiplier, a 20-step square root, a normalize shift and a 16-step CORDIC;
//    a degenerate batch stops early and goes straight to the result.
//  - A finished result sits in the output register; the next input is taken
//    while it waits, and a new result waits only if the old one is still stalled.
//  - Reset clears the sums and count and loads the default calibration.

module tilt_compensated_heading (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  thc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output thc_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic signed [11:0]  cfg_data
);

	thc_pkg::cmd_t    cmd;
	thc_pkg::status_t status;
	logic             cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	thc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	thc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

@@ bench/tilt_compensated_heading_check.sv @@
`timescale 1ns / 1ps
// Checker for the tilt-compensated heading block: watches the input, config and
// output channels, predicts every heading result and compares it field by field.
// Depends on thc_pkg for the item types and the batch and CORDIC sizes.

module tilt_compensated_heading_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  thc_pkg::in_item_t   in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  thc_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic signed [11:0]  cfg_data,
	output int                  fail_count,
	output int                  headings_pending,
	output int                  headings_seen
);

	localparam longint ATAN_DEG_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic signed [11:0] span_min [3];
	logic signed [11:0] span_max [3];
	longint             accel_acc [3];
	longint             mag_acc [3];
	int                 batch_fill;
	logic               span_zero;
	thc_pkg::out_item_t heading_queue [$];

	function automatic longint unsigned abs64(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Map one raw magnetometer reading into Q2.14 across its calibrated span.
	function automatic longint scaled_axis(input longint m, input longint mn, input longint mx,
			output logic zero);
		longint span, num, q;
		longint unsigned as;
		span = mx - mn;
		zero = (span == 0);
		if (zero)
			return 0;
		num = (m - mn) * 32768;
		as = abs64(span);
		q = longint'((abs64(num) + as / 2) / as);
		if ((num < 0) != (span < 0))
			q = -q;
		q = q - 16384;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q;
	endfunction

	function automatic longint first_quadrant_angle(input longint x, input longint y);
		longint z, xs, ys;
		z = 0;
		for (int i = 0; i < thc_pkg::CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_DEG_Q16[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_DEG_Q16[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > 90 * 65536)
			z = 90 * 65536;
		return z;
	endfunction

	function automatic thc_pkg::out_item_t batch_heading();
		thc_pkg::out_item_t res;
		longint ax, ay, az, mx, my, mz, ex, ey, ez, ny, yv, xv, ang;
		longint unsigned ux, uy, nrm, r;
		ax = accel_acc[0]; ay = accel_acc[1]; az = accel_acc[2];
		mx = mag_acc[0]; my = mag_acc[1]; mz = mag_acc[2];
		ex = my * az - mz * ay;
		ey = mz * ax - mx * az;
		ez = mx * ay - my * ax;
		res = '0;
		if (span_zero || (ex == 0 && ey == 0 && ez == 0)) begin
			res.degenerate = 1'b1;
			return res;
		end
		nrm = int_sqrt(ax * ax + ay * ay + az * az);
		ny = az * ex - ax * ez;
		yv = -ey * longint'(nrm);
		xv = -ny;
		ux = abs64(xv);
		uy = abs64(yv);
		while ((ux | uy) >= (64'd1 << 30)) begin
			ux = ux >> 1;
			uy = uy >> 1;
		end
		ang = first_quadrant_angle(ux, uy);
		if (xv < 0)
			ang = 180 * 65536 - ang;
		if (yv < 0)
			ang = -ang;
		r = (abs64(ang) + 32768) >> 16;
		if (ang < 0 && r > 0)
			r = 360 - r;
		if (r > 359)
			r = r - 360;
		res.heading_deg = r[8:0];
		res.ribbon_offset = 6'((r + 5) / 10);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic z;
		thc_pkg::out_item_t want;
		if (!arst_n) begin
			span_min = '{-12'sd642, -12'sd496, -12'sd462};
			span_max = '{12'sd340, 12'sd517, 12'sd416};
			accel_acc = '{0, 0, 0};
			mag_acc = '{0, 0, 0};
			batch_fill = 0;
			span_zero = 1'b0;
			heading_queue.delete();
			fail_count = 0;
			headings_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					thc_pkg::CFG_MIN_X: span_min[0] = cfg_data;
					thc_pkg::CFG_MIN_Y: span_min[1] = cfg_data;
					thc_pkg::CFG_MIN_Z: span_min[2] = cfg_data;
					thc_pkg::CFG_MAX_X: span_max[0] = cfg_data;
					thc_pkg::CFG_MAX_Y: span_max[1] = cfg_data;
					thc_pkg::CFG_MAX_Z: span_max[2] = cfg_data;
					default: ; // drop writes to unused indexes
				endcase
			end
			if (out_valid && !out_stall) begin
				headings_seen++;
				if (heading_queue.size() == 0) begin
					$error("heading result with none expected: %p", out_data);
					fail_count++;
				end else begin
					want = heading_queue.pop_front();
					if (out_data.heading_deg !== want.heading_deg) begin
						$error("heading_deg: expected %0d, got %0d",
							want.heading_deg, out_data.heading_deg);
						fail_count++;
					end
					if (out_data.ribbon_offset !== want.ribbon_offset) begin
						$error("ribbon_offset: expected %0d, got %0d",
							want.ribbon_offset, out_data.ribbon_offset);
						fail_count++;
					end
					if (out_data.degenerate !== want.degenerate) begin
						$error("degenerate: expected %0d, got %0d",
							want.degenerate, out_data.degenerate);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				accel_acc[0] += longint'(in_data.accel_x);
				accel_acc[1] += longint'(in_data.accel_y);
				accel_acc[2] += longint'(in_data.accel_z);
				mag_acc[0] += scaled_axis(in_data.mag_x, span_min[0], span_max[0], z);
				span_zero |= z;
				mag_acc[1] += scaled_axis(in_data.mag_y, span_min[1], span_max[1], z);
				span_zero |= z;
				mag_acc[2] += scaled_axis(in_data.mag_z, span_min[2], span_max[2], z);
				span_zero |= z;
				batch_fill++;
				if (batch_fill >= thc_pkg::AVG_COUNT) begin
					heading_queue.push_back(batch_heading());
					accel_acc = '{0, 0, 0};
					mag_acc = '{0, 0, 0};
					batch_fill = 0;
					span_zero = 1'b0;
				end
			end
		end
		headings_pending = heading_queue.size();
	end

endmodule

@@ bench/tilt_compensated_heading_test.sv @@
`timescale 1ns / 1ps
// Top of the heading testbench: clock, reset, sample and calibration stimulus,
// receiver stalls and the verdict. Depends on thc_pkg, the block and the checker.

module tilt_compensated_heading_test;

	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD = 700;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	thc_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	thc_pkg::out_item_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic signed [11:0] cfg_data = '0;

	int  fail_count, headings_pending, headings_seen;
	int  samples_sent = 0;
	int  reg_writes = 0;
	int  quiet_cycles = 0;
	bit  idle_on = 1'b0;
	bit  hold_request = 1'b0;
	int  span_lo [3] = '{-642, -496, -462};
	int  span_hi [3] = '{340, 517, 416};

	always #6 clk = ~clk;

	tilt_compensated_heading uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tilt_compensated_heading_check check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .headings_pending(headings_pending),
		.headings_seen(headings_seen)
	);

	// Watchdog: count cycles with no transfer on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tilt_compensated_heading_test: FAIL");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
				out_stall = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_sample(input thc_pkg::in_item_t item);
		in_data = item;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		samples_sent++;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	task automatic send_axes(input int ax, ay, az, mx, my, mz);
		thc_pkg::in_item_t item;
		item.accel_x = 16'(ax); item.accel_y = 16'(ay); item.accel_z = 16'(az);
		item.mag_x = 12'(mx); item.mag_y = 12'(my); item.mag_z = 12'(mz);
		send_sample(item);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int value);
		cfg_index = idx;
		cfg_data = 12'(value);
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_span(input thc_pkg::cfg_idx_t lo_idx, input thc_pkg::cfg_idx_t hi_idx,
			input int axis, input int lo, input int hi);
		write_reg(lo_idx, lo);
		write_reg(hi_idx, hi);
		span_lo[axis] = lo;
		span_hi[axis] = hi;
	endtask

	task automatic set_all_spans(input int lo, input int hi);
		set_span(thc_pkg::CFG_MIN_X, thc_pkg::CFG_MAX_X, 0, lo, hi);
		set_span(thc_pkg::CFG_MIN_Y, thc_pkg::CFG_MAX_Y, 1, lo, hi);
		set_span(thc_pkg::CFG_MIN_Z, thc_pkg::CFG_MAX_Z, 2, lo, hi);
	endtask

	// Drop valid, wait for every heading, then let trailing samples finish.
	task automatic drain();
		in_valid = 1'b0;
		while (headings_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int mag_in_span(input int axis);
		int lo, hi;
		lo = span_lo[axis] < span_hi[axis] ? span_lo[axis] : span_hi[axis];
		hi = span_lo[axis] < span_hi[axis] ? span_hi[axis] : span_lo[axis];
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Mostly plausible tilt and field readings; the rest is raw noise.
	function automatic thc_pkg::in_item_t random_sample();
		thc_pkg::in_item_t item;
		item = thc_pkg::in_item_t'(84'({$urandom, $urandom, $urandom}));
		if ($urandom_range(0, 9) < 7) begin
			item.accel_x = 16'(int'($urandom_range(0, 16000)) - 8000);
			item.accel_y = 16'(int'($urandom_range(0, 16000)) - 8000);
			item.accel_z = 16'(int'($urandom_range(8000, 17000)));
			if ($urandom_range(0, 3) == 0)
				item.accel_z = -item.accel_z;
			item.mag_x = 12'(mag_in_span(0));
			item.mag_y = 12'(mag_in_span(1));
			item.mag_z = 12'(mag_in_span(2));
		end
		return item;
	endfunction

	task automatic random_phase(input int n, input bit idle);
		idle_on = idle;
		repeat (n) send_sample(random_sample());
		drain();
	endtask

	initial begin
		int lo, hi;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Field extremes under the reset calibration.
		send_axes(32767, -32768, 0, 2047, -2048, 0);
		send_axes(-32768, 32767, 32767, -2048, 2047, -2048);
		send_axes(0, 0, -32768, 0, 0, 2047);
		send_axes(32767, 32767, 32767, 2047, 2047, 2047);
		send_axes(-32768, -32768, -32768, -2048, -2048, -2048);
		// Level, nose at the four compass points.
		send_axes(0, 0, 16384, 340, 10, -20);
		send_axes(0, 0, 16384, -642, 10, -20);
		send_axes(0, 0, 16384, 10, 517, -20);
		send_axes(0, 0, 16384, 10, -496, -20);
		send_axes(0, 0, 16384, 340, 517, -20);
		// Zero acceleration: cross product vanishes.
		repeat (5) send_axes(0, 0, 0, 300, -200, 100);
		// Field parallel to gravity (both nearly centered on X and Y).
		repeat (5) send_axes(0, 0, 16384, -151, 11, 416);
		// Mixed tilt.
		send_axes(4000, -3000, 15000, 200, 100, -300);
		send_axes(-5000, 2000, 14000, -400, 300, 200);
		send_axes(3000, 3000, -15000, 100, -450, 0);
		send_axes(-16000, 100, 100, 0, 0, 400);
		send_axes(100, -16000, 200, -600, 500, -100);
		drain();

		// Full span, with a long receiver hold so the block backs up.
		set_all_spans(-2048, 2047);
		hold_request = 1'b1;
		random_phase(150, 1'b1);

		// Inverted spans.
		set_all_spans(2047, -2048);
		random_phase(150, 1'b1);

		// Zero span on Y alone, then on X and Z together.
		set_span(thc_pkg::CFG_MIN_Y, thc_pkg::CFG_MAX_Y, 1, 100, 100);
		random_phase(50, 1'b1);
		set_span(thc_pkg::CFG_MIN_Y, thc_pkg::CFG_MAX_Y, 1, -2048, 2047);
		set_span(thc_pkg::CFG_MIN_X, thc_pkg::CFG_MAX_X, 0, -2048, -2048);
		set_span(thc_pkg::CFG_MIN_Z, thc_pkg::CFG_MAX_Z, 2, 2047, 2047);
		random_phase(50, 1'b0);

		// Very narrow spans saturate the scaled values.
		set_all_spans(-1, 0);
		random_phase(100, 1'b1);

		// Writes to unused indexes must be dropped.
		write_reg(CFG_SPARE_LO, -2048);
		write_reg(CFG_SPARE_HI, 2047);
		set_span(thc_pkg::CFG_MIN_X, thc_pkg::CFG_MAX_X, 0, -642, 340);
		set_span(thc_pkg::CFG_MIN_Y, thc_pkg::CFG_MAX_Y, 1, -496, 517);
		set_span(thc_pkg::CFG_MIN_Z, thc_pkg::CFG_MAX_Z, 2, -462, 416);
		random_phase(200, 1'b1);

		// Random calibrations.
		repeat (4) begin
			for (int a = 0; a < 3; a++) begin
				lo = int'($urandom_range(0, 4095)) - 2048;
				hi = int'($urandom_range(0, 4095)) - 2048;
				if (a == 0)
					set_span(thc_pkg::CFG_MIN_X, thc_pkg::CFG_MAX_X, a, lo, hi);
				else if (a == 1)
					set_span(thc_pkg::CFG_MIN_Y, thc_pkg::CFG_MAX_Y, a, lo, hi);
				else
					set_span(thc_pkg::CFG_MIN_Z, thc_pkg::CFG_MAX_Z, a, lo, hi);
			end
			random_phase(125, $urandom_range(0, 1));
		end

		// Last stretch at full rate.
		set_all_spans(-700, 700);
		random_phase(150, 1'b0);

		$display("covered %0d samples and %0d register writes; %0d headings checked",
			samples_sent, reg_writes, headings_seen);
		$display("spans: reset, full, inverted, zero, narrow and random; one long output hold");
		if (fail_count == 0 && headings_pending == 0)
			$display("tilt_compensated_heading_test: PASS");
		else
			$display("tilt_compensated_heading_test: FAIL");
		$finish;
	end

endmodule
